/* src/pcc_pkg.sv */
// Shared types and constants for the pointing path clearance check unit.
// Used by the front, queue, back and top level modules; no dependencies.
package pcc_pkg;

   localparam int ZONE_COUNT  = 32;
   localparam int ZONE_IDX_W  = 5;
   localparam int FRAC_BITS   = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 2;

   // Divider sizes for the seam elevation: dividend 2|num|+den, divisor 2den
   localparam int DIVD_W = 38;
   localparam int DIVS_W = 18;
   localparam int DCNT_W = 6;

   typedef logic signed [16:0] angle_type;
   typedef logic signed [25:0] coord_type;
   typedef logic signed [27:0] num_type;
   typedef logic signed [55:0] prod_type;

   localparam logic signed [17:0] HALF_TURN = 18'(180 * (2 ** FRAC_BITS));
   localparam logic signed [18:0] FULL_TURN = 19'(360 * (2 ** FRAC_BITS));
   localparam logic signed [39:0] SEAM_SAT  = 40'sd16777216;

   localparam logic [1:0] PROF_DIAG     = 2'd0;
   localparam logic [1:0] PROF_AZ_FIRST = 2'd1;
   localparam logic [1:0] PROF_EL_FIRST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WRAP    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE = 1'd1;

   localparam logic FUNC_WRITE = 1'b0;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_SEG   = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ZONE_IDX_W-1:0]   slot;
      logic                    enable;
      angle_type               az_lo;
      angle_type               el_lo;
      angle_type               az_hi;
      angle_type               el_hi;
      coord_type               ax;
      coord_type               ay;
      coord_type               bx;
      coord_type               by;
   } entry_type;

endpackage

/* src/pcc_queue.sv */
// Short in-order queue of commands between the front and back parts.
// Depends on pcc_pkg for the entry type and depth.
module pcc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pcc_pkg::entry_type push_entry,
   input  logic               pop,
   output pcc_pkg::entry_type head_entry,
   output logic               full,
   output logic               empty
);

   pcc_pkg::entry_type               slots_ff [pcc_pkg::QUEUE_DEPTH];
   logic [pcc_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [pcc_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [pcc_pkg::QPTR_W:0]         count_ff;

   assign full       = (count_ff == (pcc_pkg::QPTR_W+1)'(pcc_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* src/pcc_front.sv */
// Front part: takes requests, builds path legs, splits legs at the azimuth
// seam (serial divider for the seam elevation) and queues commands. Uses pcc_pkg.
module pcc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cfg_wrap,
   input  logic [1:0]                      cfg_profile,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [pcc_pkg::ZONE_IDX_W-1:0]  req_zone_slot,
   input  logic                            req_zone_enable,
   input  pcc_pkg::angle_type              req_zone_az_low,
   input  pcc_pkg::angle_type              req_zone_el_low,
   input  pcc_pkg::angle_type              req_zone_az_high,
   input  pcc_pkg::angle_type              req_zone_el_high,
   input  pcc_pkg::angle_type              req_start_az,
   input  pcc_pkg::angle_type              req_start_el,
   input  pcc_pkg::angle_type              req_end_az,
   input  pcc_pkg::angle_type              req_end_el,
   output logic                            q_push,
   output pcc_pkg::entry_type              q_entry,
   input  logic                            q_full
);

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_LEG  = 6'b000010,
      F_DIV  = 6'b000100,
      F_SEG1 = 6'b001000,
      F_SEG2 = 6'b010000,
      F_DONE = 6'b100000
   } fstate_type;

   fstate_type                      state_ff, state_in;
   pcc_pkg::angle_type              saz_ff, sel_ff, eaz_ff, eel_ff;
   logic                            leg_ff, leg_in;
   logic                            neg_ff;
   logic [pcc_pkg::DIVD_W-1:0]      divd_ff;
   logic [pcc_pkg::DIVD_W-1:0]      quot_ff;
   logic [pcc_pkg::DIVS_W-1:0]      dsor_ff;
   logic [pcc_pkg::DIVS_W:0]        rem_ff;
   logic [pcc_pkg::DCNT_W-1:0]      cnt_ff;
   pcc_pkg::coord_type              el_ff;

   pcc_pkg::angle_type              ax, ay, bx, by;
   logic                            two_legs;
   logic signed [17:0]              daz, dy, seam;
   logic signed [18:0]              eff, seam_dx;
   logic signed [36:0]              num;
   logic [36:0]                     num_mag;
   logic [16:0]                     den_mag;
   logic                            split;
   logic [pcc_pkg::DIVS_W+1:0]      rem_sh;
   logic                            q_bit;
   logic signed [38:0]              q_signed;
   logic signed [39:0]              el_wide;
   pcc_pkg::coord_type              el_sat;
   pcc_pkg::coord_type              seam_c;
   logic                            accept;

   // Leg endpoints for the selected motion profile
   always_comb begin
      ax = saz_ff;
      ay = sel_ff;
      bx = eaz_ff;
      by = eel_ff;
      case (cfg_profile)
         pcc_pkg::PROF_AZ_FIRST: begin
            if (!leg_ff) by = sel_ff;
            else         ax = eaz_ff;
         end
         pcc_pkg::PROF_EL_FIRST: begin
            if (!leg_ff) bx = saz_ff;
            else         ay = eel_ff;
         end
         default: ;
      endcase
   end

   assign two_legs = (cfg_profile == pcc_pkg::PROF_AZ_FIRST) ||
                     (cfg_profile == pcc_pkg::PROF_EL_FIRST);

   assign daz     = $signed({bx[16], bx}) - $signed({ax[16], ax});
   assign dy      = $signed({by[16], by}) - $signed({ay[16], ay});
   assign split   = cfg_wrap && ((daz > pcc_pkg::HALF_TURN) || (daz < -pcc_pkg::HALF_TURN));
   assign eff     = (daz < 0) ? ($signed({daz[17], daz}) + pcc_pkg::FULL_TURN)
                              : ($signed({daz[17], daz}) - pcc_pkg::FULL_TURN);
   assign seam    = (daz < 0) ? pcc_pkg::HALF_TURN : -pcc_pkg::HALF_TURN;
   assign seam_dx = $signed({seam[17], seam}) - $signed({{2{ax[16]}}, ax});
   assign num     = seam_dx * dy;
   assign num_mag = num[36] ? 37'(-num) : 37'(num);
   assign den_mag = eff[18] ? 17'(-eff) : 17'(eff);
   assign seam_c  = {{8{seam[17]}}, seam};

   // Restoring divider step, one quotient bit per cycle
   assign rem_sh = {rem_ff, divd_ff[pcc_pkg::DIVD_W-1]};
   assign q_bit  = (rem_sh >= {2'b00, dsor_ff});

   assign q_signed = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
   assign el_wide  = $signed({{23{ay[16]}}, ay}) + $signed({q_signed[38], q_signed});
   always_comb begin
      if (el_wide > pcc_pkg::SEAM_SAT)       el_sat = 26'(pcc_pkg::SEAM_SAT);
      else if (el_wide < -pcc_pkg::SEAM_SAT) el_sat = 26'(-pcc_pkg::SEAM_SAT);
      else                                   el_sat = el_wide[25:0];
   end

   assign req_ready = (state_ff == F_IDLE) && !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      leg_in   = leg_ff;
      q_push   = 1'b0;
      q_entry  = '0;
      q_entry.kind = pcc_pkg::KIND_SEG;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_func == pcc_pkg::FUNC_WRITE) begin
                  q_push         = 1'b1;
                  q_entry.kind   = pcc_pkg::KIND_WRITE;
                  q_entry.slot   = req_zone_slot;
                  q_entry.enable = req_zone_enable;
                  q_entry.az_lo  = req_zone_az_low;
                  q_entry.el_lo  = req_zone_el_low;
                  q_entry.az_hi  = req_zone_az_high;
                  q_entry.el_hi  = req_zone_el_high;
               end else begin
                  leg_in   = 1'b0;
                  state_in = F_LEG;
               end
            end
         end
         F_LEG: begin
            q_entry.ax = {{9{ax[16]}}, ax};
            q_entry.ay = {{9{ay[16]}}, ay};
            q_entry.bx = {{9{bx[16]}}, bx};
            q_entry.by = {{9{by[16]}}, by};
            if (split && (eff != 0)) begin
               state_in = F_DIV;
            end else if (split || !q_full) begin
               q_push = !split;
               if (two_legs && !leg_ff) leg_in = 1'b1;
               else                     state_in = F_DONE;
            end
         end
         F_DIV: begin
            if (cnt_ff == '0) state_in = F_SEG1;
         end
         F_SEG1: begin
            q_entry.ax = {{9{ax[16]}}, ax};
            q_entry.ay = {{9{ay[16]}}, ay};
            q_entry.bx = seam_c;
            q_entry.by = el_sat;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_SEG2;
            end
         end
         F_SEG2: begin
            q_entry.ax = -seam_c;
            q_entry.ay = el_ff;
            q_entry.bx = {{9{bx[16]}}, bx};
            q_entry.by = {{9{by[16]}}, by};
            if (!q_full) begin
               q_push = 1'b1;
               if (two_legs && !leg_ff) begin
                  leg_in   = 1'b1;
                  state_in = F_LEG;
               end else begin
                  state_in = F_DONE;
               end
            end
         end
         F_DONE: begin
            q_entry.kind = pcc_pkg::KIND_DONE;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         leg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         leg_ff   <= leg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         saz_ff <= req_start_az;
         sel_ff <= req_start_el;
         eaz_ff <= req_end_az;
         eel_ff <= req_end_el;
      end
      if (state_ff == F_LEG) begin
         neg_ff  <= num[36] ^ eff[18];
         divd_ff <= {num_mag, 1'b0} + {21'd0, den_mag};
         dsor_ff <= {den_mag, 1'b0};
         rem_ff  <= '0;
         quot_ff <= '0;
         cnt_ff  <= pcc_pkg::DCNT_W'(pcc_pkg::DIVD_W);
      end else if ((state_ff == F_DIV) && (cnt_ff != '0)) begin
         divd_ff <= {divd_ff[pcc_pkg::DIVD_W-2:0], 1'b0};
         rem_ff  <= q_bit ? (pcc_pkg::DIVS_W+1)'(rem_sh - {2'b00, dsor_ff})
                          : rem_sh[pcc_pkg::DIVS_W:0];
         quot_ff <= {quot_ff[pcc_pkg::DIVD_W-2:0], q_bit};
         cnt_ff  <= cnt_ff - 1'b1;
      end
      if (state_ff == F_SEG1) begin
         el_ff <= el_sat;
      end
   end

endmodule

/* src/pcc_back.sv */
// Back part: owns the zone table; until the query hits, sweeps each segment past all
// zones in a read/setup/multiply/compare pipeline; returns responses. Uses pcc_pkg.
module pcc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  pcc_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_path_clear
);

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_SWEEP = 3'b010,
      B_DRAIN = 3'b100
   } bstate_type;

   bstate_type                          state_ff, state_in;
   logic [33:0]                         az_mem [pcc_pkg::ZONE_COUNT];
   logic [33:0]                         el_mem [pcc_pkg::ZONE_COUNT];
   logic [pcc_pkg::ZONE_COUNT-1:0]      vld_ff;
   logic [pcc_pkg::ZONE_IDX_W-1:0]      addr_ff;
   pcc_pkg::entry_type                  seg_ff;
   logic [33:0]                         rd_az_ff, rd_el_ff;
   logic                                rd_v_ff;
   logic                                s1_vld_ff, s2_vld_ff, s3_vld_ff;
   pcc_pkg::num_type                    lo_a_ff, hi_a_ff, dd_a_ff;
   pcc_pkg::num_type                    lo_e_ff, hi_e_ff, dd_e_ff;
   logic                                both_ff, ok_ff, both3_ff, ok3_ff;
   pcc_pkg::prod_type                   p1_ff, p2_ff, p3_ff, p4_ff;
   logic                                hit_ff;
   logic                                rsp_valid_ff, rsp_clear_ff;

   pcc_pkg::num_type azl, azh, ell, elh, ax, ay, bx, by;
   pcc_pkg::num_type d_a, d_e, lo_a, hi_a, dd_a, lo_e, hi_e, dd_e;
   logic             pres_a, pres_e, ok_a, ok_e, nonempty, hit3;
   logic             out_free, is_seg, take;

   assign azl = 28'(rd_az_ff[16:0]  ^ 17'h10000) - 28'sd65536;
   assign azh = 28'(rd_az_ff[33:17] ^ 17'h10000) - 28'sd65536;
   assign ell = 28'(rd_el_ff[16:0]  ^ 17'h10000) - 28'sd65536;
   assign elh = 28'(rd_el_ff[33:17] ^ 17'h10000) - 28'sd65536;
   assign ax  = {{2{seg_ff.ax[25]}}, seg_ff.ax};
   assign ay  = {{2{seg_ff.ay[25]}}, seg_ff.ay};
   assign bx  = {{2{seg_ff.bx[25]}}, seg_ff.bx};
   assign by  = {{2{seg_ff.by[25]}}, seg_ff.by};

   // Per-axis entry/exit parameters as numerator over positive denominator
   always_comb begin
      d_a    = bx - ax;
      d_e    = by - ay;
      pres_a = (d_a != 0);
      pres_e = (d_e != 0);
      if (d_a > 0) begin
         lo_a = azl - ax; hi_a = azh - ax; dd_a = d_a;
      end else begin
         lo_a = ax - azh; hi_a = ax - azl; dd_a = -d_a;
      end
      if (d_e > 0) begin
         lo_e = ell - ay; hi_e = elh - ay; dd_e = d_e;
      end else begin
         lo_e = ay - elh; hi_e = ay - ell; dd_e = -d_e;
      end
      ok_a = pres_a ? ((lo_a < dd_a) && (hi_a > 0)) : ((ax > azl) && (ax < azh));
      ok_e = pres_e ? ((lo_e < dd_e) && (hi_e > 0)) : ((ay > ell) && (ay < elh));
      nonempty = (azl < azh) && (ell < elh);
   end

   assign hit3 = ok3_ff && (!both3_ff || ((p1_ff < p2_ff) && (p3_ff < p4_ff)));

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_seg   = (q_entry.kind == pcc_pkg::KIND_SEG);
   assign take     = (state_ff == B_IDLE) && !q_empty;
   assign q_pop    = take && (is_seg || out_free);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (q_pop && is_seg && !hit_ff) state_in = B_SWEEP;
         B_SWEEP: if (addr_ff == pcc_pkg::ZONE_IDX_W'(pcc_pkg::ZONE_COUNT - 1))
                     state_in = B_DRAIN;
         B_DRAIN: if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_clear = rsp_clear_ff;

   always_ff @(posedge clock) begin
      if (q_pop && (q_entry.kind == pcc_pkg::KIND_WRITE)) begin
         az_mem[q_entry.slot] <= {q_entry.az_hi, q_entry.az_lo};
         el_mem[q_entry.slot] <= {q_entry.el_hi, q_entry.el_lo};
      end
      rd_az_ff <= az_mem[addr_ff];
      rd_el_ff <= el_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         vld_ff       <= '0;
         addr_ff      <= '0;
         rd_v_ff      <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= vld_ff[addr_ff];
         s1_vld_ff <= (state_ff == B_SWEEP);
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         if (state_ff == B_SWEEP) begin
            addr_ff <= addr_ff + 1'b1;
         end else begin
            addr_ff <= '0;
         end
         if (rsp_ready && !(q_pop && !is_seg)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s3_vld_ff && hit3) begin
            hit_ff <= 1'b1;
         end
         if (q_pop) begin
            case (q_entry.kind)
               pcc_pkg::KIND_WRITE: begin
                  vld_ff[q_entry.slot] <= q_entry.enable;
                  rsp_valid_ff         <= 1'b1;
               end
               pcc_pkg::KIND_DONE: begin
                  hit_ff       <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         seg_ff <= q_entry;
         case (q_entry.kind)
            pcc_pkg::KIND_WRITE: rsp_clear_ff <= 1'b0;
            pcc_pkg::KIND_DONE:  rsp_clear_ff <= !hit_ff;
            default: ;
         endcase
      end
      lo_a_ff  <= lo_a;  hi_a_ff <= hi_a;  dd_a_ff <= dd_a;
      lo_e_ff  <= lo_e;  hi_e_ff <= hi_e;  dd_e_ff <= dd_e;
      both_ff  <= pres_a && pres_e;
      ok_ff    <= rd_v_ff && nonempty && ok_a && ok_e;
      p1_ff    <= lo_a_ff * dd_e_ff;
      p2_ff    <= hi_e_ff * dd_a_ff;
      p3_ff    <= lo_e_ff * dd_a_ff;
      p4_ff    <= hi_a_ff * dd_e_ff;
      both3_ff <= both_ff;
      ok3_ff   <= ok_ff;
   end

endmodule

/* src/pointing_path_clearance_check_unit.sv */
// Top level of the pointing path clearance check: control registers and the
// front / queue / back parts. Depends on pcc_pkg, pcc_front, pcc_queue, pcc_back.
// Zone write: queued by the front part and answered by the back part when popped.
// Query: each sub-segment, unless a hit is already recorded, sweeps all 32 zones,
// one zone per cycle, then the pipeline drains; up to 4 sub-segments, and a seam
// split adds a serial division. Items are handled one at a time per part.
// Synchronous reset clears all zone valid bits, the registers, queue and handshakes.
module pointing_path_clearance_check_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [pcc_pkg::ZONE_IDX_W-1:0]    req_zone_slot,
   input  logic                              req_zone_enable,
   input  pcc_pkg::angle_type                req_zone_az_low,
   input  pcc_pkg::angle_type                req_zone_el_low,
   input  pcc_pkg::angle_type                req_zone_az_high,
   input  pcc_pkg::angle_type                req_zone_el_high,
   input  pcc_pkg::angle_type                req_start_az,
   input  pcc_pkg::angle_type                req_start_el,
   input  pcc_pkg::angle_type                req_end_az,
   input  pcc_pkg::angle_type                req_end_el,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_path_clear,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic               wrap_ff;
   logic [1:0]         profile_ff;
   logic               q_push, q_pop, q_full, q_empty;
   pcc_pkg::entry_type push_entry, head_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff    <= 1'b0;
         profile_ff <= pcc_pkg::PROF_DIAG;
      end else if (csr_valid) begin
         case (csr_index)
            pcc_pkg::CSR_WRAP:    wrap_ff    <= csr_wdata[0];
            pcc_pkg::CSR_PROFILE: profile_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pcc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg_wrap         (wrap_ff),
      .cfg_profile      (profile_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_zone_slot    (req_zone_slot),
      .req_zone_enable  (req_zone_enable),
      .req_zone_az_low  (req_zone_az_low),
      .req_zone_el_low  (req_zone_el_low),
      .req_zone_az_high (req_zone_az_high),
      .req_zone_el_high (req_zone_el_high),
      .req_start_az     (req_start_az),
      .req_start_el     (req_start_el),
      .req_end_az       (req_end_az),
      .req_end_el       (req_end_el),
      .q_push           (q_push),
      .q_entry          (push_entry),
      .q_full           (q_full)
   );

   pcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   pcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_entry        (head_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_clear (rsp_path_clear)
   );

endmodule

/* src/pcc_checker.sv */
// Port-level checks for the pointing path clearance check unit, bound to the top.
// Depends on pcc_pkg for port widths.
module pcc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_path_clear,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [pcc_pkg::CSR_IDX_W-1:0]  csr_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_path_clear))
      else $error("response changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !$isunknown(csr_index) |-> csr_ready)
      else $error("register write not taken");

endmodule

bind pointing_path_clearance_check_unit pcc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_path_clear (rsp_path_clear),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready),
   .csr_index      (csr_index)
);

/* tb/tb_top.sv */
// Self-checking testbench for pointing_path_clearance_check_unit: drives zone
// writes and path queries, predicts path_clear with a local clipping model.
// Depends on pcc_pkg and the unit's RTL.
module tb_top;
   import pcc_pkg::*;

   localparam logic       FUNC_QUERY   = 1'b1;
   localparam logic [1:0] PROF_SPARE   = 2'd3;
   localparam int         DRAIN_CYCLES = 300;
   localparam longint     CYCLE_LIMIT  = 2000000;
   localparam longint     HALF         = 180 * 128;
   localparam longint     FULL         = 360 * 128;
   localparam longint     SAT          = 64'sd1 << 24;
   localparam int         AMAX         = 46080;

   typedef struct {
      logic                  func;
      logic [ZONE_IDX_W-1:0] slot;
      logic                  enable;
      angle_type             az_lo, el_lo, az_hi, el_hi;
      angle_type             s_az, s_el, e_az, e_el;
   } move_item;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic [ZONE_IDX_W-1:0] req_zone_slot = '0;
   logic req_zone_enable = 1'b0;
   angle_type req_zone_az_low = '0, req_zone_el_low = '0;
   angle_type req_zone_az_high = '0, req_zone_el_high = '0;
   angle_type req_start_az = '0, req_start_el = '0, req_end_az = '0, req_end_el = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_path_clear;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the zone table and registers
   bit     zone_on [ZONE_COUNT];
   longint zone_azl [ZONE_COUNT], zone_azh [ZONE_COUNT];
   longint zone_ell [ZONE_COUNT], zone_elh [ZONE_COUNT];
   bit       wrap_on = 0;
   bit [1:0] profile = PROF_DIAG;

   move_item move_pending_q[$];
   bit       clear_expect_q[$];
   int       errors = 0;
   int       csr_writes = 0;
   longint   cycles = 0;
   int       req_gap = 0, rsp_stall = 0;
   bit       burst = 0;

   pointing_path_clearance_check_unit dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit before_ratio(longint an, longint ad, longint bn, longint bd);
      return an * bd < bn * ad;
   endfunction

   function automatic bit zone_hit(longint ax, longint ay, longint bx, longint by, int z);
      longint lo_n[3], lo_d[3], hi_n[3], hi_d[3];
      longint p[2], d[2], lo[2], hi[2];
      int cnt;
      cnt = 1;
      if (zone_azl[z] >= zone_azh[z] || zone_ell[z] >= zone_elh[z]) return 0;
      lo_n[0] = 0; lo_d[0] = 1; hi_n[0] = 1; hi_d[0] = 1;
      p[0] = ax; d[0] = bx - ax; lo[0] = zone_azl[z]; hi[0] = zone_azh[z];
      p[1] = ay; d[1] = by - ay; lo[1] = zone_ell[z]; hi[1] = zone_elh[z];
      for (int k = 0; k < 2; k++) begin
         if (d[k] == 0) begin
            if (!(p[k] > lo[k] && p[k] < hi[k])) return 0;
         end else if (d[k] > 0) begin
            lo_n[cnt] = lo[k] - p[k]; hi_n[cnt] = hi[k] - p[k];
            lo_d[cnt] = d[k]; hi_d[cnt] = d[k]; cnt++;
         end else begin
            lo_n[cnt] = p[k] - hi[k]; hi_n[cnt] = p[k] - lo[k];
            lo_d[cnt] = -d[k]; hi_d[cnt] = -d[k]; cnt++;
         end
      end
      for (int i = 0; i < cnt; i++)
         for (int j = 0; j < cnt; j++)
            if (!before_ratio(lo_n[i], lo_d[i], hi_n[j], hi_d[j])) return 0;
      return 1;
   endfunction

   function automatic bit segment_clear(longint ax, longint ay, longint bx, longint by);
      for (int z = 0; z < ZONE_COUNT; z++)
         if (zone_on[z] && zone_hit(ax, ay, bx, by, z)) return 0;
      return 1;
   endfunction

   function automatic bit leg_clear(longint ax, longint ay, longint bx, longint by);
      longint daz, eff, seam, num, den, q, el;
      daz = bx - ax;
      if (wrap_on && (daz > HALF || daz < -HALF)) begin
         if (daz < -HALF) begin
            eff = daz + FULL; seam = HALF;
         end else begin
            eff = daz - FULL; seam = -HALF;
         end
         if (eff == 0) return 1;
         num = (seam - ax) * (by - ay);
         den = eff;
         if (den < 0) begin
            den = -den; num = -num;
         end
         // round to nearest, ties away from zero
         if (num >= 0) q = (2 * num + den) / (2 * den);
         else q = -((-2 * num + den) / (2 * den));
         el = ay + q;
         if (el > SAT) el = SAT;
         if (el < -SAT) el = -SAT;
         if (!segment_clear(ax, ay, seam, el)) return 0;
         return segment_clear(-seam, el, bx, by);
      end
      return segment_clear(ax, ay, bx, by);
   endfunction

   // updates the table for writes, returns expected path_clear
   function automatic bit predict_clear(move_item it);
      longint sa, se, ea, ee;
      if (it.func == FUNC_WRITE) begin
         zone_on[it.slot] = it.enable;
         zone_azl[it.slot] = it.az_lo; zone_azh[it.slot] = it.az_hi;
         zone_ell[it.slot] = it.el_lo; zone_elh[it.slot] = it.el_hi;
         return 0;
      end
      sa = it.s_az; se = it.s_el; ea = it.e_az; ee = it.e_el;
      case (profile)
         PROF_AZ_FIRST: return leg_clear(sa, se, ea, se) && leg_clear(ea, se, ea, ee);
         PROF_EL_FIRST: return leg_clear(sa, se, sa, ee) && leg_clear(sa, ee, ea, ee);
         default:       return leg_clear(sa, se, ea, ee);
      endcase
   endfunction

   function automatic angle_type rand_angle(int span);
      return angle_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic angle_type clamp_angle(int v);
      return angle_type'((v > AMAX) ? AMAX : (v < -AMAX) ? -AMAX : v);
   endfunction

   task automatic push_zone(int slot, bit en, int azl, int ell, int azh, int elh);
      move_item it;
      it = '{default: '0};
      it.func = FUNC_WRITE; it.slot = ZONE_IDX_W'(slot); it.enable = en;
      it.az_lo = angle_type'(azl); it.el_lo = angle_type'(ell);
      it.az_hi = angle_type'(azh); it.el_hi = angle_type'(elh);
      move_pending_q.push_back(it);
   endtask

   task automatic push_move(int sa, int se, int ea, int ee);
      move_item it;
      it = '{default: '0};
      it.func = FUNC_QUERY;
      it.s_az = angle_type'(sa); it.s_el = angle_type'(se);
      it.e_az = angle_type'(ea); it.e_el = angle_type'(ee);
      // zone fields are don't-care for queries; keep them toggling
      it.slot = ZONE_IDX_W'($urandom); it.enable = 1'($urandom);
      it.az_lo = rand_angle(AMAX); it.az_hi = rand_angle(AMAX);
      it.el_lo = rand_angle(AMAX); it.el_hi = rand_angle(AMAX);
      move_pending_q.push_back(it);
   endtask

   task automatic add_directed();
      push_zone(0, 1, -1280, -1280, 1280, 1280);
      push_zone(31, 0, -AMAX, -AMAX, AMAX, AMAX);
      push_zone(5, 1, 500, 500, 500, 9000);
      push_zone(6, 1, 21000, 0, 23040, 2560);
      push_zone(7, 1, -23040, -2560, -21000, 0);
      push_move(-5000, -5000, 5000, 5000);
      push_move(1280, -5000, 1280, 5000);
      push_move(0, -5000, 0, 5000);
      push_move(-1280, 1280, 1280, 3840);
      push_move(-2560, 0, 0, 2560);
      push_move(-AMAX, -AMAX, AMAX, AMAX);
      push_move(AMAX, AMAX, -AMAX, -AMAX);
      push_move(-23040, 1000, 23040, 1000);
      push_move(22000, 1000, -22000, 1000);
      push_move(-22000, -1000, 22000, -1000);
      push_move(22000, -5000, -22000, 5000);
      push_move(100, 100, 100, 100);
      push_move(-AMAX, 0, AMAX, 0);
   endtask

   task automatic add_random(int count);
      int a, e, w;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            a = rand_angle(23040); e = rand_angle(11520);
            w = $urandom_range(1, 6000);
            if ($urandom_range(0, 9) == 0)
               push_zone($urandom_range(0, 31), 1'($urandom), rand_angle(AMAX),
                         rand_angle(AMAX), rand_angle(AMAX), rand_angle(AMAX));
            else
               push_zone($urandom_range(0, 31), $urandom_range(0, 4) != 0, a, e,
                         clamp_angle(a + w), clamp_angle(e + $urandom_range(1, 6000)));
         end else if ($urandom_range(0, 9) == 0) begin
            push_move(rand_angle(AMAX), rand_angle(AMAX), rand_angle(AMAX), rand_angle(AMAX));
         end else begin
            a = rand_angle(23040); e = rand_angle(11520);
            case ($urandom_range(0, 5))
               0:       push_move(a, e, a, rand_angle(11520));
               1:       push_move(a, e, rand_angle(23040), e);
               default: push_move(a, e, rand_angle(23040), rand_angle(11520));
            endcase
         end
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      int n;
      n = csr_writes;
      @(posedge clock);
      csr_index <= idx; csr_wdata <= val; csr_valid <= 1'b1;
      wait (csr_writes != n);
   endtask

   task automatic run_phase(bit wrap, logic [1:0] prof, bit directed, int count);
      write_csr(CSR_WRAP, {1'b0, wrap});
      write_csr(CSR_PROFILE, prof);
      burst = $urandom_range(0, 2) == 0;
      if (directed) add_directed();
      add_random(count);
      wait (move_pending_q.size() == 0 && !req_valid && clear_expect_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      run_phase(0, PROF_DIAG, 1, 50);
      run_phase(1, PROF_DIAG, 1, 60);
      run_phase(1, PROF_AZ_FIRST, 0, 60);
      run_phase(0, PROF_EL_FIRST, 0, 60);
      run_phase(1, PROF_EL_FIRST, 0, 60);
      run_phase(1, PROF_SPARE, 0, 50);
      run_phase(0, PROF_AZ_FIRST, 0, 60);
      run_phase(1, PROF_DIAG, 0, 60);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WRAP) wrap_on = csr_wdata[0];
         else profile = csr_wdata;
         csr_valid <= 1'b0;
         csr_writes++;
      end
   end

   task automatic load_item(move_item it);
      req_func <= it.func; req_zone_slot <= it.slot; req_zone_enable <= it.enable;
      req_zone_az_low <= it.az_lo; req_zone_el_low <= it.el_lo;
      req_zone_az_high <= it.az_hi; req_zone_el_high <= it.el_hi;
      req_start_az <= it.s_az; req_start_el <= it.s_el;
      req_end_az <= it.e_az; req_end_el <= it.e_el;
   endtask

   // request driver; the payload in flight is mirrored in cur_item
   move_item cur_item;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         clear_expect_q.push_back(predict_clear(cur_item));
         req_gap = burst ? 0 : $urandom_range(0, 9);
         if (req_gap == 0 && move_pending_q.size() > 0) begin
            cur_item = move_pending_q.pop_front();
            load_item(cur_item);
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (move_pending_q.size() > 0) begin
            cur_item = move_pending_q.pop_front();
            load_item(cur_item);
            req_valid <= 1'b1;
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (clear_expect_q.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, got path_clear %0b",
                        $time, rsp_path_clear);
               errors++;
            end else if (clear_expect_q[0] !== rsp_path_clear) begin
               $display("%0t: path_clear mismatch, expected %0b, got %0b",
                        $time, clear_expect_q[0], rsp_path_clear);
               errors++;
               void'(clear_expect_q.pop_front());
            end else begin
               void'(clear_expect_q.pop_front());
            end
            rsp_stall = burst ? 0 : $urandom_range(0, 9);
            if (rsp_stall != 0) rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            if (rsp_stall > 0) rsp_stall--;
            else rsp_ready <= 1'b1;
         end
      end
   end

endmodule
